// ----- src/cts_pkg.sv -----
// Shared types, codes and constants for the cooperative task scheduler.
// Used by cts_deadline and cooperative_task_scheduler_unit; no dependencies.
package cts_pkg;

   localparam int DEFAULT_NUM_TASKS = 16;
   localparam logic [19:0] MS_TO_NS = 20'd1000000;
   localparam int MUL_STEPS = 20;
   localparam logic [62:0] DEADLINE_MAX = {63{1'b1}};

   typedef enum logic [2:0] {
      KIND_CREATE   = 3'd0,
      KIND_AWAIT    = 3'd1,
      KIND_SLEEP    = 3'd2,
      KIND_COMPLETE = 3'd3,
      KIND_SCHEDULE = 3'd4,
      KIND_READ     = 3'd5,
      KIND_RESUME   = 3'd6,
      KIND_NOP      = 3'd7
   } kind_type;

   typedef enum logic [3:0] {
      STAT_OK           = 4'd0,
      STAT_DISPATCHED   = 4'd1,
      STAT_ROOT_DONE    = 4'd2,
      STAT_WAIT_UNTIL   = 4'd3,
      STAT_DEADLOCK     = 4'd4,
      STAT_DOUBLE_CMPL  = 4'd5,
      STAT_AWAIT_CMPL   = 4'd6,
      STAT_UNREGISTERED = 4'd7,
      STAT_INCOMPLETE   = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      TS_RUNNING  = 3'd0,
      TS_SLEEPING = 3'd1,
      TS_WAITING  = 3'd2,
      TS_READY    = 3'd3,
      TS_COMPLETE = 3'd4
   } task_st_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_MUL,
      FSM_INSERT,
      FSM_DRAIN,
      FSM_WAKE,
      FSM_POP,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [3:0]         task_id;
      logic [3:0]         dep_id;
      logic [3:0]         root_id;
      logic signed [63:0] sleep_ms;
      logic [62:0]        now_ns;
      logic signed [63:0] value_in;
   } req_type;

   typedef struct packed {
      logic [3:0]         status;
      logic [3:0]         task_out;
      logic signed [63:0] value_out;
      logic               task_done;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [62:0] ms;
      logic [62:0] now;
   } mul_ctl_type;

   function automatic int slot_of(int v, int n);
      int r;
      r = v;
      for (int i = 0; i < 8; i++) begin
         if (r >= n) begin
            r = r - n;
         end
      end
      return r;
   endfunction

endpackage

// ----- src/cts_deadline.sv -----
// Shift-add unit: deadline = now + ms * 1e6, saturated to the 63-bit maximum.
// Depends on cts_pkg.
module cts_deadline (
   input  logic                 clock,
   input  logic                 reset,
   input  cts_pkg::mul_ctl_type ctl,
   output logic                 done,
   output logic [62:0]          deadline
);

   logic [83:0] acc_ff, acc_in;
   logic [62:0] ms_ff, ms_in;
   logic [4:0]  idx_ff, idx_in;
   logic        run_ff, run_in;

   always_comb begin
      acc_in = acc_ff;
      ms_in  = ms_ff;
      idx_in = idx_ff;
      run_in = run_ff;
      if (ctl.start) begin
         acc_in = {21'd0, ctl.now};
         ms_in  = ctl.ms;
         idx_in = 5'd0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (cts_pkg::MS_TO_NS[idx_ff]) begin
            acc_in = acc_ff + ({21'd0, ms_ff} << idx_ff);
         end
         idx_in = idx_ff + 5'd1;
         if (idx_ff == 5'(cts_pkg::MUL_STEPS - 1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      ms_ff  <= ms_in;
      idx_ff <= idx_in;
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   assign done     = run_ff && (idx_ff == 5'(cts_pkg::MUL_STEPS - 1));
   assign deadline = (acc_in > {21'd0, cts_pkg::DEADLINE_MAX}) ?
                     cts_pkg::DEADLINE_MAX : acc_in[62:0];

endmodule

// ----- src/cooperative_task_scheduler_unit.sv -----
// Cooperative task scheduler: slot tables, list-walk sequencer, result port.
// Simple items go from exec to the result; sleep multiplies, then walks the sleep list to
// insert; complete moves the waiters to the ready list; schedule pops the ready list,
// first waking due sleepers if it is empty. List walks advance one link per cycle, the
// multiply one bit per cycle. Busy holds through the strobe cycle; the next item is taken
// in the cycle after it. Results are never held off. Synchronous reset runs every slot, lists empty.
module cooperative_task_scheduler_unit #(
   parameter int NUM_TASKS = cts_pkg::DEFAULT_NUM_TASKS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cts_pkg::req_type req_item,
   output logic             rsp_strobe,
   output cts_pkg::rsp_type rsp_item
);

   localparam int IW = $clog2(NUM_TASKS + 1);
   localparam int AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam logic [IW-1:0] NIL = IW'(NUM_TASKS);

   cts_pkg::fsm_type fsm_ff, fsm_in;
   cts_pkg::req_type req_ff;

   cts_pkg::task_st_type st_ff [NUM_TASKS];
   logic [IW-1:0] link_ff [NUM_TASKS];
   logic [IW-1:0] wh_ff [NUM_TASKS];
   logic [IW-1:0] wt_ff [NUM_TASKS];
   logic [62:0]   dl_ff [NUM_TASKS];
   logic [63:0]   res_ff [NUM_TASKS];
   logic [IW-1:0] rh_ff, rt_ff, sh_ff;

   logic [IW-1:0] prev_ff, cur_ff, steps_ff;
   logic [62:0]   d_ff;
   logic [3:0]    status_ff, tout_ff;
   logic [63:0]   value_ff;

   logic [AW-1:0] t_idx, dep_idx, root_idx;
   logic [IW-1:0] t_ptr;
   cts_pkg::mul_ctl_type mul_ctl;
   logic          mul_done;
   logic [62:0]   mul_deadline;
   logic          ins_go, drain_go, wake_go;

   assign t_idx    = AW'(cts_pkg::slot_of(int'(req_ff.task_id), NUM_TASKS));
   assign dep_idx  = AW'(cts_pkg::slot_of(int'(req_ff.dep_id), NUM_TASKS));
   assign root_idx = AW'(cts_pkg::slot_of(int'(req_ff.root_id), NUM_TASKS));
   assign t_ptr    = IW'(t_idx);

   assign mul_ctl.start = (fsm_ff == cts_pkg::FSM_EXEC) &&
                          (cts_pkg::kind_type'(req_ff.kind) == cts_pkg::KIND_SLEEP);
   assign mul_ctl.ms    = req_ff.sleep_ms[63] ? 63'd0 : req_ff.sleep_ms[62:0];
   assign mul_ctl.now   = req_ff.now_ns;

   cts_deadline u_deadline (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mul_ctl),
      .done     (mul_done),
      .deadline (mul_deadline)
   );

   assign ins_go   = (cur_ff != NIL) && (steps_ff < IW'(NUM_TASKS)) &&
                     (dl_ff[cur_ff[AW-1:0]] <= d_ff);
   assign drain_go = (cur_ff != NIL) && (steps_ff < IW'(NUM_TASKS));
   assign wake_go  = (sh_ff != NIL) && (steps_ff < IW'(NUM_TASKS)) &&
                     (dl_ff[sh_ff[AW-1:0]] <= req_ff.now_ns);

   always_comb begin
      fsm_in = fsm_ff;
      unique case (fsm_ff)
         cts_pkg::FSM_IDLE: begin
            if (start) fsm_in = cts_pkg::FSM_EXEC;
         end
         cts_pkg::FSM_EXEC: begin
            fsm_in = cts_pkg::FSM_DONE;
            case (cts_pkg::kind_type'(req_ff.kind))
               cts_pkg::KIND_SLEEP: fsm_in = cts_pkg::FSM_MUL;
               cts_pkg::KIND_COMPLETE: begin
                  if (st_ff[t_idx] != cts_pkg::TS_COMPLETE) fsm_in = cts_pkg::FSM_DRAIN;
               end
               cts_pkg::KIND_SCHEDULE: begin
                  if (st_ff[root_idx] != cts_pkg::TS_COMPLETE) begin
                     fsm_in = (rh_ff != NIL) ? cts_pkg::FSM_POP : cts_pkg::FSM_WAKE;
                  end
               end
               default: fsm_in = cts_pkg::FSM_DONE;
            endcase
         end
         cts_pkg::FSM_MUL: begin
            if (mul_done) fsm_in = cts_pkg::FSM_INSERT;
         end
         cts_pkg::FSM_INSERT: begin
            if (!ins_go) fsm_in = cts_pkg::FSM_DONE;
         end
         cts_pkg::FSM_DRAIN: begin
            if (!drain_go) fsm_in = cts_pkg::FSM_DONE;
         end
         cts_pkg::FSM_WAKE: begin
            if (!wake_go) fsm_in = cts_pkg::FSM_POP;
         end
         cts_pkg::FSM_POP: fsm_in = cts_pkg::FSM_DONE;
         cts_pkg::FSM_DONE: fsm_in = cts_pkg::FSM_IDLE;
         default: fsm_in = cts_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      busy       = (fsm_ff != cts_pkg::FSM_IDLE);
      rsp_strobe = (fsm_ff == cts_pkg::FSM_DONE);
      rsp_item.status    = status_ff;
      rsp_item.task_out  = tout_ff;
      rsp_item.value_out = value_ff;
      rsp_item.task_done = (st_ff[t_idx] == cts_pkg::TS_COMPLETE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= cts_pkg::FSM_IDLE;
         rh_ff  <= NIL;
         rt_ff  <= NIL;
         sh_ff  <= NIL;
         for (int i = 0; i < NUM_TASKS; i++) begin
            st_ff[i]   <= cts_pkg::TS_RUNNING;
            link_ff[i] <= NIL;
            wh_ff[i]   <= NIL;
            wt_ff[i]   <= NIL;
            dl_ff[i]   <= '0;
            res_ff[i]  <= '0;
         end
      end else begin
         fsm_ff <= fsm_in;
         case (fsm_ff)
            cts_pkg::FSM_IDLE: begin
               if (start) begin
                  req_ff    <= req_item;
                  status_ff <= cts_pkg::STAT_OK;
                  tout_ff   <= req_item.task_id;
                  value_ff  <= 64'd0;
               end
            end
            cts_pkg::FSM_EXEC: begin
               steps_ff <= '0;
               case (cts_pkg::kind_type'(req_ff.kind))
                  cts_pkg::KIND_CREATE: begin
                     st_ff[t_idx]   <= cts_pkg::TS_RUNNING;
                     res_ff[t_idx]  <= 64'd0;
                     dl_ff[t_idx]   <= 63'd0;
                     wh_ff[t_idx]   <= NIL;
                     wt_ff[t_idx]   <= NIL;
                     link_ff[t_idx] <= NIL;
                  end
                  cts_pkg::KIND_AWAIT: begin
                     if (st_ff[dep_idx] == cts_pkg::TS_COMPLETE) begin
                        status_ff <= cts_pkg::STAT_AWAIT_CMPL;
                     end else begin
                        st_ff[t_idx]   <= cts_pkg::TS_WAITING;
                        link_ff[t_idx] <= NIL;
                        if (wh_ff[dep_idx] == NIL) wh_ff[dep_idx] <= t_ptr;
                        else link_ff[wt_ff[dep_idx][AW-1:0]] <= t_ptr;
                        wt_ff[dep_idx] <= t_ptr;
                     end
                  end
                  cts_pkg::KIND_COMPLETE: begin
                     if (st_ff[t_idx] == cts_pkg::TS_COMPLETE) begin
                        status_ff <= cts_pkg::STAT_DOUBLE_CMPL;
                     end else begin
                        res_ff[t_idx] <= req_ff.value_in;
                        st_ff[t_idx]  <= cts_pkg::TS_COMPLETE;
                        cur_ff        <= wh_ff[t_idx];
                        wh_ff[t_idx]  <= NIL;
                        wt_ff[t_idx]  <= NIL;
                     end
                  end
                  cts_pkg::KIND_SCHEDULE: begin
                     if (st_ff[root_idx] == cts_pkg::TS_COMPLETE) begin
                        status_ff <= cts_pkg::STAT_ROOT_DONE;
                     end
                  end
                  cts_pkg::KIND_READ: begin
                     if (st_ff[t_idx] == cts_pkg::TS_COMPLETE) value_ff <= res_ff[t_idx];
                     else status_ff <= cts_pkg::STAT_INCOMPLETE;
                  end
                  cts_pkg::KIND_RESUME: begin
                     if (st_ff[t_idx] == cts_pkg::TS_RUNNING) begin
                        status_ff <= cts_pkg::STAT_UNREGISTERED;
                     end
                  end
                  default: status_ff <= cts_pkg::STAT_OK;
               endcase
            end
            cts_pkg::FSM_MUL: begin
               if (mul_done) begin
                  st_ff[t_idx] <= cts_pkg::TS_SLEEPING;
                  dl_ff[t_idx] <= mul_deadline;
                  d_ff         <= mul_deadline;
                  prev_ff      <= NIL;
                  cur_ff       <= sh_ff;
               end
            end
            cts_pkg::FSM_INSERT: begin
               if (ins_go) begin
                  prev_ff  <= cur_ff;
                  cur_ff   <= link_ff[cur_ff[AW-1:0]];
                  steps_ff <= steps_ff + 1'b1;
               end else begin
                  link_ff[t_idx] <= cur_ff;
                  if (prev_ff == NIL) sh_ff <= t_ptr;
                  else link_ff[prev_ff[AW-1:0]] <= t_ptr;
               end
            end
            cts_pkg::FSM_DRAIN: begin
               if (drain_go) begin
                  cur_ff   <= link_ff[cur_ff[AW-1:0]];
                  steps_ff <= steps_ff + 1'b1;
                  st_ff[cur_ff[AW-1:0]]   <= cts_pkg::TS_READY;
                  link_ff[cur_ff[AW-1:0]] <= NIL;
                  if (rt_ff != NIL) link_ff[rt_ff[AW-1:0]] <= cur_ff;
                  else rh_ff <= cur_ff;
                  rt_ff <= cur_ff;
               end
            end
            cts_pkg::FSM_WAKE: begin
               if (wake_go) begin
                  sh_ff    <= link_ff[sh_ff[AW-1:0]];
                  steps_ff <= steps_ff + 1'b1;
                  st_ff[sh_ff[AW-1:0]]   <= cts_pkg::TS_READY;
                  link_ff[sh_ff[AW-1:0]] <= NIL;
                  if (rt_ff != NIL) link_ff[rt_ff[AW-1:0]] <= sh_ff;
                  else rh_ff <= sh_ff;
                  rt_ff <= sh_ff;
               end
            end
            cts_pkg::FSM_POP: begin
               if (rh_ff != NIL) begin
                  rh_ff <= link_ff[rh_ff[AW-1:0]];
                  if (link_ff[rh_ff[AW-1:0]] == NIL) rt_ff <= NIL;
                  link_ff[rh_ff[AW-1:0]] <= NIL;
                  st_ff[rh_ff[AW-1:0]]   <= cts_pkg::TS_RUNNING;
                  status_ff <= cts_pkg::STAT_DISPATCHED;
                  tout_ff   <= 4'(rh_ff);
               end else if (sh_ff != NIL) begin
                  status_ff <= cts_pkg::STAT_WAIT_UNTIL;
                  value_ff  <= {1'b0, dl_ff[sh_ff[AW-1:0]]};
               end else begin
                  status_ff <= cts_pkg::STAT_DEADLOCK;
               end
            end
            default: begin
               status_ff <= status_ff;
            end
         endcase
      end
   end

endmodule

// ----- dv/cooperative_task_scheduler_unit_tb.sv -----
// Self-checking testbench for cooperative_task_scheduler_unit: drives scheduler
// events through the start/busy port and checks every strobed result against
// a behavioral task-table model. Depends on cts_pkg and the scheduler RTL.
module cooperative_task_scheduler_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NT = 16;
   localparam logic [4:0] NIL = 5'd16;
   localparam int IDLE_LIMIT = 5000;

   class sched_scoreboard;
      cts_pkg::task_st_type tstate[NT];
      logic [4:0] nxt[NT];
      logic [4:0] whead[NT];
      logic [4:0] wtail[NT];
      logic [62:0] deadline[NT];
      logic [63:0] result[NT];
      logic [4:0] rhead, rtail, shead;
      cts_pkg::rsp_type pending[$];
      int errors;

      function void clear();
         for (int i = 0; i < NT; i++) begin
            tstate[i] = cts_pkg::TS_RUNNING;
            nxt[i] = NIL;
            whead[i] = NIL;
            wtail[i] = NIL;
            deadline[i] = '0;
            result[i] = '0;
         end
         rhead = NIL;
         rtail = NIL;
         shead = NIL;
         errors = 0;
      endfunction

      function void push_ready(logic [4:0] t);
         tstate[t] = cts_pkg::TS_READY;
         nxt[t] = NIL;
         if (rtail != NIL) begin
            nxt[rtail] = t;
         end else begin
            rhead = t;
         end
         rtail = t;
      endfunction

      function logic [4:0] pop_ready();
         logic [4:0] t;
         t = rhead;
         if (t != NIL) begin
            rhead = nxt[t];
            if (rhead == NIL) begin
               rtail = NIL;
            end
            nxt[t] = NIL;
         end
         return t;
      endfunction

      function void note_item(cts_pkg::req_type r);
         cts_pkg::rsp_type e;
         logic [4:0] t, dep, root, p, prev, cur, w, nx;
         logic [63:0] ms;
         logic [62:0] d;
         int steps;
         t = {1'b0, r.task_id};
         dep = {1'b0, r.dep_id};
         root = {1'b0, r.root_id};
         e.status = cts_pkg::STAT_OK;
         e.task_out = r.task_id;
         e.value_out = '0;
         case (cts_pkg::kind_type'(r.kind))
            cts_pkg::KIND_CREATE: begin
               tstate[t] = cts_pkg::TS_RUNNING;
               result[t] = '0;
               deadline[t] = '0;
               whead[t] = NIL;
               wtail[t] = NIL;
               nxt[t] = NIL;
            end
            cts_pkg::KIND_AWAIT: begin
               if (tstate[dep] == cts_pkg::TS_COMPLETE) begin
                  e.status = cts_pkg::STAT_AWAIT_CMPL;
               end else begin
                  tstate[t] = cts_pkg::TS_WAITING;
                  nxt[t] = NIL;
                  if (whead[dep] == NIL) begin
                     whead[dep] = t;
                  end else begin
                     nxt[wtail[dep]] = t;
                  end
                  wtail[dep] = t;
               end
            end
            cts_pkg::KIND_SLEEP: begin
               ms = r.sleep_ms[63] ? 64'd0 : r.sleep_ms;
               tstate[t] = cts_pkg::TS_SLEEPING;
               if (ms > 64'((cts_pkg::DEADLINE_MAX - r.now_ns) / 63'd1000000)) begin
                  d = cts_pkg::DEADLINE_MAX;
               end else begin
                  d = r.now_ns + 63'(ms * 64'd1000000);
               end
               deadline[t] = d;
               prev = NIL;
               cur = shead;
               steps = 0;
               while (cur != NIL && steps < NT && deadline[cur] <= d) begin
                  prev = cur;
                  cur = nxt[cur];
                  steps++;
               end
               nxt[t] = cur;
               if (prev == NIL) begin
                  shead = t;
               end else begin
                  nxt[prev] = t;
               end
            end
            cts_pkg::KIND_COMPLETE: begin
               if (tstate[t] == cts_pkg::TS_COMPLETE) begin
                  e.status = cts_pkg::STAT_DOUBLE_CMPL;
               end else begin
                  w = whead[t];
                  result[t] = r.value_in;
                  tstate[t] = cts_pkg::TS_COMPLETE;
                  whead[t] = NIL;
                  wtail[t] = NIL;
                  steps = 0;
                  while (w != NIL && steps < NT) begin
                     nx = nxt[w];
                     push_ready(w);
                     w = nx;
                     steps++;
                  end
               end
            end
            cts_pkg::KIND_SCHEDULE: begin
               if (tstate[root] == cts_pkg::TS_COMPLETE) begin
                  e.status = cts_pkg::STAT_ROOT_DONE;
               end else begin
                  p = pop_ready();
                  if (p == NIL) begin
                     steps = 0;
                     while (shead != NIL && steps < NT && deadline[shead] <= r.now_ns) begin
                        nx = shead;
                        shead = nxt[nx];
                        push_ready(nx);
                        steps++;
                     end
                     p = pop_ready();
                  end
                  if (p != NIL) begin
                     tstate[p] = cts_pkg::TS_RUNNING;
                     e.status = cts_pkg::STAT_DISPATCHED;
                     e.task_out = p[3:0];
                  end else if (shead != NIL) begin
                     e.status = cts_pkg::STAT_WAIT_UNTIL;
                     e.value_out = {1'b0, deadline[shead]};
                  end else begin
                     e.status = cts_pkg::STAT_DEADLOCK;
                  end
               end
            end
            cts_pkg::KIND_READ: begin
               if (tstate[t] == cts_pkg::TS_COMPLETE) begin
                  e.value_out = result[t];
               end else begin
                  e.status = cts_pkg::STAT_INCOMPLETE;
               end
            end
            cts_pkg::KIND_RESUME: begin
               if (tstate[t] == cts_pkg::TS_RUNNING) begin
                  e.status = cts_pkg::STAT_UNREGISTERED;
               end
            end
            default: begin
            end
         endcase
         e.task_done = (tstate[t] == cts_pkg::TS_COMPLETE);
         pending.push_back(e);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch %s: got %0h expected %0h", what, got, want);
         errors++;
      endtask

      task check_result(cts_pkg::rsp_type g);
         cts_pkg::rsp_type e;
         if (pending.size() == 0) begin
            report("unexpected result", 64'(g.status), 64'd0);
            return;
         end
         e = pending.pop_front();
         if (g.status !== e.status) report("status", 64'(g.status), 64'(e.status));
         if (g.task_out !== e.task_out) report("task_out", 64'(g.task_out), 64'(e.task_out));
         if (g.value_out !== e.value_out) report("value_out", g.value_out, e.value_out);
         if (g.task_done !== e.task_done)
            report("task_done", 64'(g.task_done), 64'(e.task_done));
      endtask
   endclass

   logic clock, reset, start, busy, rsp_strobe;
   cts_pkg::req_type req_item;
   cts_pkg::rsp_type rsp_item;
   sched_scoreboard board;
   int idle_pct;
   int quiet_cycles;
   logic [62:0] clock_ns;

   cooperative_task_scheduler_unit #(.NUM_TASKS(NT)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            board.check_result(rsp_item);
         end
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("cooperative_task_scheduler_unit_tb: FAIL");
            $finish;
         end
      end
   end

   task automatic send(cts_pkg::req_type r);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      board.note_item(r);
      @(negedge clock);
   endtask

   function automatic cts_pkg::req_type make_item(cts_pkg::kind_type k, int t, int dep,
                                                  int root, logic [63:0] ms,
                                                  logic [62:0] now, logic [63:0] v);
      cts_pkg::req_type r;
      r.kind = k;
      r.task_id = t[3:0];
      r.dep_id = dep[3:0];
      r.root_id = root[3:0];
      r.sleep_ms = ms;
      r.now_ns = now;
      r.value_in = v;
      return r;
   endfunction

   function automatic cts_pkg::req_type random_item();
      int sel;
      logic [63:0] ms;
      logic [62:0] now;
      cts_pkg::kind_type k;
      sel = $urandom_range(99);
      if (sel < 14) k = cts_pkg::KIND_CREATE;
      else if (sel < 30) k = cts_pkg::KIND_AWAIT;
      else if (sel < 45) k = cts_pkg::KIND_SLEEP;
      else if (sel < 60) k = cts_pkg::KIND_COMPLETE;
      else if (sel < 82) k = cts_pkg::KIND_SCHEDULE;
      else if (sel < 90) k = cts_pkg::KIND_READ;
      else if (sel < 98) k = cts_pkg::KIND_RESUME;
      else k = cts_pkg::KIND_NOP;
      case ($urandom_range(9))
         0: ms = {$urandom, $urandom};
         1: ms = 64'h7fff_ffff_ffff_ffff;
         2: ms = -64'sd5;
         default: ms = 64'($urandom_range(50));
      endcase
      if ($urandom_range(19) == 0) begin
         now = 63'({$urandom, $urandom});
      end else begin
         clock_ns = clock_ns + 63'($urandom_range(20000000));
         now = clock_ns;
      end
      return make_item(k, $urandom_range(15), $urandom_range(15), $urandom_range(15),
                       ms, now, {$urandom, $urandom});
   endfunction

   initial begin
      board = new();
      board.clear();
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      idle_pct = 0;
      quiet_cycles = 0;
      clock_ns = 63'd1000;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      send(make_item(cts_pkg::KIND_SCHEDULE, 0, 0, 3, '0, '0, '0));
      send(make_item(cts_pkg::KIND_RESUME, 2, 0, 0, '0, '0, '0));
      send(make_item(cts_pkg::KIND_READ, 2, 0, 0, '0, '0, '0));
      send(make_item(cts_pkg::KIND_SLEEP, 1, 0, 0, 64'h7fff_ffff_ffff_ffff,
                     cts_pkg::DEADLINE_MAX, '0));
      send(make_item(cts_pkg::KIND_SLEEP, 2, 0, 0, 64'h8000_0000_0000_0000, 63'd500, '0));
      send(make_item(cts_pkg::KIND_SLEEP, 3, 0, 0, 64'd0, 63'd500, '0));
      send(make_item(cts_pkg::KIND_SLEEP, 4, 0, 0, 64'd3, 63'd0, '0));
      send(make_item(cts_pkg::KIND_SCHEDULE, 0, 0, 15, '0, 63'd100, '0));
      send(make_item(cts_pkg::KIND_SCHEDULE, 0, 0, 15, '0, 63'd600, '0));
      send(make_item(cts_pkg::KIND_SCHEDULE, 0, 0, 15, '0, 63'd600, '0));
      send(make_item(cts_pkg::KIND_AWAIT, 5, 0, 7, '0, '0, '0));
      send(make_item(cts_pkg::KIND_AWAIT, 6, 7, 0, '0, '0, '0));
      send(make_item(cts_pkg::KIND_RESUME, 5, 0, 0, '0, '0, '0));
      send(make_item(cts_pkg::KIND_COMPLETE, 7, 0, 0, '0, '0, 64'hffff_ffff_ffff_ffff));
      send(make_item(cts_pkg::KIND_COMPLETE, 7, 0, 0, '0, '0, 64'h1));
      send(make_item(cts_pkg::KIND_AWAIT, 8, 7, 0, '0, '0, '0));
      send(make_item(cts_pkg::KIND_READ, 7, 0, 0, '0, '0, '0));
      send(make_item(cts_pkg::KIND_SCHEDULE, 0, 0, 15, '0, 63'd0, '0));
      send(make_item(cts_pkg::KIND_SCHEDULE, 0, 0, 7, '0, 63'd0, '0));
      send(make_item(cts_pkg::KIND_NOP, 15, 15, 15, 64'hffff_ffff_ffff_ffff,
                     cts_pkg::DEADLINE_MAX, 64'h8000_0000_0000_0000));
      send(make_item(cts_pkg::KIND_CREATE, 7, 0, 0, '0, '0, '0));
      send(make_item(cts_pkg::KIND_SCHEDULE, 0, 0, 15, '0, cts_pkg::DEADLINE_MAX, '0));
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 13 : (phase == 1) ? 85 : 0;
         for (int n = 0; n < 450; n++) begin
            send(random_item());
         end
      end
      start <= 1'b0;
      while (board.pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (60) @(posedge clock);
      if (board.errors == 0) begin
         $display("cooperative_task_scheduler_unit_tb: PASS");
      end else begin
         $display("cooperative_task_scheduler_unit_tb: FAIL");
      end
      $finish;
   end
endmodule
